/* rtl/core/tevq_pkg.sv */
// shared types and codes of the time ordered event queue
package tevq_pkg;

  // operation codes of a request
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_INS0,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_DONE
  } state_e;

  // source of data written into the slot memory
  typedef enum logic {
    WSRC_NEW,
    WSRC_RD
  } wsrc_e;

  // request payload
  typedef struct packed {
    logic        kind;
    logic [31:0] event_time;
    logic [15:0] payload_tag;
  } tevq_req_t;

  // result payload
  typedef struct packed {
    status_e     status;
    logic [31:0] head_time;
    logic [15:0] head_tag;
    logic [4:0]  entry_count;
    logic        is_empty;
  } tevq_rsp_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic  load;
    logic  rd_en;
    logic  wr_en;
    wsrc_e wr_src;
    logic  cap_head;
  } dp_ctrl_t;

endpackage

/* rtl/core/tevq_dp.sv */
// slot memory, entry registers and the shared time comparator
module tevq_dp import tevq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                           clk_i,
  input  dp_ctrl_t                       ctrl_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr_i,
  input  tevq_req_t                      req_i,
  output logic                           rd_gt_o,
  output logic [31:0]                    head_time_o,
  output logic [15:0]                    head_tag_o
);

  localparam int EW = 32 + TAG_WIDTH;

  logic [EW-1:0]        mem [QUEUE_DEPTH];
  logic [EW-1:0]        rd_q;
  logic [EW-1:0]        wr_data;
  logic [31:0]          new_time_q;
  logic [TAG_WIDTH-1:0] new_tag_q;
  logic [31:0]          head_time_q;
  logic [TAG_WIDTH-1:0] head_tag_q;
  logic [31:0]          tag_in_ext;
  logic [31:0]          tag_out_ext;
  logic [31:0]          rd_time;

  // tag kept in its low TAG_WIDTH bits
  assign tag_in_ext = 32'(req_i.payload_tag);
  assign rd_time    = rd_q[EW-1:TAG_WIDTH];

  // write data: new entry or the slot just read
  assign wr_data = (ctrl_i.wr_src == WSRC_RD) ? rd_q : {new_time_q, new_tag_q};

  // slot memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // entry and head registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      new_time_q  <= req_i.event_time;
      new_tag_q   <= tag_in_ext[TAG_WIDTH-1:0];
      head_time_q <= '0;
      head_tag_q  <= '0;
    end else if (ctrl_i.cap_head) begin
      head_time_q <= rd_time;
      head_tag_q  <= rd_q[TAG_WIDTH-1:0];
    end
  end

  // shared compare: stored slot later than the new entry
  assign rd_gt_o = rd_time > new_time_q;

  assign tag_out_ext = 32'(head_tag_q);
  assign head_time_o = head_time_q;
  assign head_tag_o  = tag_out_ext[15:0];

endmodule

/* rtl/core/tevq_ctrl.sv */
// sequencer that walks the slots for insertion and removal
module tevq_ctrl import tevq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             kind_i,
  input  logic                             rd_gt_i,
  output logic                             busy_o,
  output logic                             valid_o,
  output dp_ctrl_t                         ctrl_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr_o,
  output status_e                          status_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  status_e       status_q, status_d;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_p1;

  assign count_m1 = count_q - CW'(1);
  assign idx_p1   = CW'(idx_q) + CW'(1);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      count_q  <= '0;
      status_q <= ST_PUSHED;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    status_d  = status_q;
    ctrl_o    = '{load: 1'b0, rd_en: 1'b0, wr_en: 1'b0, wr_src: WSRC_NEW, cap_head: 1'b0};
    rd_addr_o = '0;
    wr_addr_o = idx_q;
    valid_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          if (kind_i == KIND_PUSH) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (count_q == '0) begin
              state_d = S_INS0;
            end else begin
              // read the last slot and walk backwards
              ctrl_o.rd_en = 1'b1;
              rd_addr_o    = count_m1[AW-1:0];
              idx_d        = count_q[AW-1:0];
              state_d      = S_PUSH_CMP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              ctrl_o.rd_en = 1'b1;
              rd_addr_o    = '0;
              state_d      = S_POP_HEAD;
            end
          end
        end
      end
      S_PUSH_CMP: begin
        ctrl_o.wr_en = 1'b1;
        wr_addr_o    = idx_q;
        if (rd_gt_i) begin
          // move the later slot up by one
          ctrl_o.wr_src = WSRC_RD;
          if (idx_q == AW'(1)) begin
            state_d = S_INS0;
          end else begin
            ctrl_o.rd_en = 1'b1;
            rd_addr_o    = idx_q - AW'(2);
            idx_d        = idx_q - AW'(1);
          end
        end else begin
          // new entry lands behind the slot just read
          ctrl_o.wr_src = WSRC_NEW;
          count_d       = count_q + CW'(1);
          status_d      = ST_PUSHED;
          state_d       = S_DONE;
        end
      end
      S_INS0: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_src = WSRC_NEW;
        wr_addr_o     = '0;
        count_d       = count_q + CW'(1);
        status_d      = ST_PUSHED;
        state_d       = S_DONE;
      end
      S_POP_HEAD: begin
        ctrl_o.cap_head = 1'b1;
        if (count_q == CW'(1)) begin
          count_d  = count_m1;
          status_d = ST_POPPED;
          state_d  = S_DONE;
        end else begin
          ctrl_o.rd_en = 1'b1;
          rd_addr_o    = AW'(1);
          idx_d        = AW'(1);
          state_d      = S_POP_SHIFT;
        end
      end
      S_POP_SHIFT: begin
        // move each slot down by one
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_src = WSRC_RD;
        wr_addr_o     = idx_q - AW'(1);
        if (idx_p1 < count_q) begin
          ctrl_o.rd_en = 1'b1;
          rd_addr_o    = idx_p1[AW-1:0];
          idx_d        = idx_p1[AW-1:0];
        end else begin
          count_d  = count_m1;
          status_d = ST_POPPED;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != S_IDLE);
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

/* rtl/core/time_ordered_event_queue.sv */
// top level of the time ordered event queue
//
// Holds up to QUEUE_DEPTH events sorted by 32-bit time, equal times in
// arrival order. A request is taken on a clock edge with start high and
// busy low; req_i.kind selects push or pop. Each request gives exactly one
// response on rsp_o, marked by valid_o for a single cycle; the receiver
// cannot stall it.
// A push walks back past the stored entries later than the new time, a pop
// shifts every remaining entry down by one, and a push into a full queue or a
// pop of an empty queue goes straight to the response.
// Each cycle the sequencer moves one slot through the single-port-read slot
// memory and the shared time comparator. busy stays high through the valid_o
// cycle and drops in the cycle after it, when the next request can be taken.
// Reset clears the entry count and the sequencer; slot contents are never
// read before they are written, so no clearing pass runs.
module time_ordered_event_queue import tevq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  tevq_req_t req_i,
  output logic      valid_o,
  output tevq_rsp_t rsp_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dp_ctrl_t      dp_ctrl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_gt;
  logic [31:0]   head_time;
  logic [15:0]   head_tag;
  status_e       status;
  logic [CW-1:0] count;
  logic [31:0]   count_ext;

  // sequencer
  tevq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (req_i.kind),
    .rd_gt_i  (rd_gt),
    .busy_o   (busy),
    .valid_o  (valid_o),
    .ctrl_o   (dp_ctrl),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr),
    .status_o (status),
    .count_o  (count)
  );

  // slot memory and comparator
  tevq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (dp_ctrl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .req_i      (req_i),
    .rd_gt_o    (rd_gt),
    .head_time_o(head_time),
    .head_tag_o (head_tag)
  );

  // response assembly
  assign count_ext         = 32'(count);
  assign rsp_o.status      = status;
  assign rsp_o.head_time   = head_time;
  assign rsp_o.head_tag    = head_tag;
  assign rsp_o.entry_count = count_ext[4:0];
  assign rsp_o.is_empty    = (count == '0);

  // a response only comes while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy)
    else $error("response outside a request");

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // the response strobe lasts one cycle and frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> (!valid_o && !busy))
    else $error("response strobe longer than one cycle");

  // only a pop returns head data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != ST_POPPED) |-> (rsp_o.head_time == '0 && rsp_o.head_tag == '0))
    else $error("head data on a non-pop response");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench of the time ordered event queue: directed and random requests, sorted-queue predictor
module tb;
  import tevq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TAG_WIDTH    = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int SETTLE_TIME  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 50;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  tevq_req_t req_i  = '0;
  logic      valid_o;
  tevq_rsp_t rsp_o;

  // predicted queue contents, sorted by time
  logic [31:0]          pending_times [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] pending_tags  [QUEUE_DEPTH];
  int                   pending_count = 0;

  tevq_rsp_t expected_rsp_q [$];
  int        error_count  = 0;
  int        cycle_count  = 0;
  int        items_sent   = 0;
  int        fill_level   = 0;
  bit        gaps_enabled = 1'b1;

  time_ordered_event_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one request to the predicted queue and return the expected response
  function automatic tevq_rsp_t apply_queue_op(tevq_req_t r);
    tevq_rsp_t rsp;
    int        pos;
    rsp = '0;
    if (r.kind == KIND_PUSH) begin
      if (pending_count >= QUEUE_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        // insert after every entry with time less or equal
        pos = 0;
        while (pos < pending_count && pending_times[pos] <= r.event_time) pos++;
        for (int i = pending_count; i > pos; i--) begin
          pending_times[i] = pending_times[i-1];
          pending_tags[i]  = pending_tags[i-1];
        end
        pending_times[pos] = r.event_time;
        pending_tags[pos]  = r.payload_tag[TAG_WIDTH-1:0];
        pending_count++;
        rsp.status = ST_PUSHED;
      end
    end else if (pending_count == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      // take the head, close the gap
      rsp.head_time = pending_times[0];
      rsp.head_tag  = 16'(pending_tags[0]);
      for (int i = 1; i < pending_count; i++) begin
        pending_times[i-1] = pending_times[i];
        pending_tags[i-1]  = pending_tags[i];
      end
      pending_count--;
      rsp.status = ST_POPPED;
    end
    rsp.entry_count = 5'(pending_count);
    rsp.is_empty    = (pending_count == 0);
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  // predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) expected_rsp_q.push_back(apply_queue_op(req_i));
  end

  // compare each response with the oldest prediction
  always @(posedge clk_i) begin
    tevq_rsp_t want;
    if (rst_ni && valid_o) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending, status", 32'(rsp_o.status), 0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(want.status));
        if (rsp_o.head_time !== want.head_time)
          report_mismatch("head_time", rsp_o.head_time, want.head_time);
        if (rsp_o.head_tag !== want.head_tag)
          report_mismatch("head_tag", 32'(rsp_o.head_tag), 32'(want.head_tag));
        if (rsp_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_o.entry_count), 32'(want.entry_count));
        if (rsp_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp_o.is_empty), 32'(want.is_empty));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // drive one request and wait until it is taken; start stays high
  task automatic send_request(input tevq_req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (r.kind == KIND_PUSH) begin
      if (fill_level < QUEUE_DEPTH) fill_level++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  // random sender gap
  task automatic maybe_idle();
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic tevq_req_t push_req(logic [31:0] t, logic [15:0] tag);
    tevq_req_t r;
    r.kind        = KIND_PUSH;
    r.event_time  = t;
    r.payload_tag = tag;
    return r;
  endfunction

  // pop with random don't-care fields
  function automatic tevq_req_t pop_req();
    tevq_req_t r;
    r.kind        = KIND_POP;
    r.event_time  = $urandom();
    r.payload_tag = 16'($urandom());
    return r;
  endfunction

  // times biased toward ties and the extremes
  function automatic logic [31:0] random_time();
    case ($urandom_range(0, 5))
      0, 1:    return 32'($urandom_range(0, 15));
      2:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      3:       return 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic tevq_req_t random_push();
    return push_req(random_time(), 16'($urandom()));
  endfunction

  // pop on empty queue, fields all ones
  task automatic test_pop_on_empty();
    send_request(push_req(32'hFFFF_FFFF, 16'hFFFF) | {1'b1, 48'h0});
    maybe_idle();
  endtask

  // extremes of time and tag, equal times keep arrival order
  task automatic test_order_and_ties();
    send_request(push_req(32'hFFFF_FFFF, 16'h0000));
    send_request(push_req(32'h0000_0000, 16'hFFFF));
    maybe_idle();
    send_request(push_req(32'd5, 16'h0001));
    send_request(push_req(32'd5, 16'h0002));
    send_request(push_req(32'hFFFF_FFFF, 16'hAAAA));
    maybe_idle();
    send_request(push_req(32'd5, 16'h0003));
    send_request(push_req(32'h0000_0000, 16'h5555));
    repeat (8) begin
      send_request(pop_req());
      maybe_idle();
    end
  endtask

  // fill up to full, then push into the full queue one to three times
  task automatic test_overflow();
    int extra;
    extra = $urandom_range(1, 3);
    while (fill_level < QUEUE_DEPTH) begin
      if ($urandom_range(0, 7) == 0) send_request(pop_req());
      else send_request(random_push());
      maybe_idle();
    end
    repeat (extra) begin
      send_request(random_push());
      maybe_idle();
    end
  endtask

  // pop until empty, then pop on the empty queue
  task automatic test_drain();
    while (fill_level > 0) begin
      if ($urandom_range(0, 7) == 0) send_request(random_push());
      else send_request(pop_req());
      maybe_idle();
    end
    repeat ($urandom_range(1, 2)) begin
      send_request(pop_req());
      maybe_idle();
    end
  endtask

  // mixed pushes and pops
  task automatic test_random_traffic(int count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) send_request(random_push());
      else send_request(pop_req());
      maybe_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pop_on_empty();
    test_order_and_ties();

    // random rounds, some without sender gaps
    while (items_sent < RANDOM_ITEMS - 2 * CALM_ITEMS) begin
      gaps_enabled = ($urandom_range(0, 2) != 0);
      test_overflow();
      test_random_traffic($urandom_range(10, 40));
      test_drain();
    end

    // last part without gaps
    gaps_enabled = 1'b0;
    test_overflow();
    test_random_traffic(CALM_ITEMS);
    test_drain();

    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TIME) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tevq_pkg.sv
rtl/core/tevq_dp.sv
rtl/core/tevq_ctrl.sv
rtl/core/time_ordered_event_queue.sv
tb/tb.sv
